/* rtl/core/sacc_pkg.sv */
// ----------------------------------------------------------------------------
// sacc_pkg
// Types, constants and helpers for the cache controller.
// ----------------------------------------------------------------------------
package sacc_pkg;

    localparam int SETS_DEF       = 16;
    localparam int WAYS_DEF       = 4;
    localparam int WPB_DEF        = 4;
    localparam int MEM_WORDS_DEF  = 1024;

    localparam int ADDR_W = 12;
    localparam int DATA_W = 32;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    localparam logic [0:0] REG_WRITE_THROUGH = 1'd0;
    localparam logic [0:0] REG_REPLACEMENT   = 1'd1;

    localparam logic [1:0] REPL_RANDOM = 2'd0;
    localparam logic [1:0] REPL_LRU    = 2'd1;

    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic                     command;
        logic [ADDR_W-1:0]        byte_address;
        logic signed [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic                     was_hit;
        logic signed [DATA_W-1:0] word_value;
        logic                     wrote_back;
        logic [DATA_W-1:0]        hit_total;
        logic [DATA_W-1:0]        miss_total;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_VICTIM,
        ST_WB_RD,
        ST_WB_WR,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_FINISH,
        ST_RD_WORD,
        ST_RESP
    } t_state;

    function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

/* rtl/core/sacc_ram.sv */
// ----------------------------------------------------------------------------
// sacc_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/set_associative_cache_controller.sv */
// ----------------------------------------------------------------------------
// set_associative_cache_controller
// Set-associative cache over an internal word memory, LRU/LIFO/random
// replacement, write-through or write-back.
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// req     | in        | i_valid/o_ready  | i_req  (t_req)
// rsp     | out       | o_valid/i_ready  | o_rsp  (t_rsp)
// cfg     | in        | i_cfg_we         | i_cfg_index, i_cfg_data
// Ways are scanned one a cycle through a single tag compare. A hit goes on
// through ST_FINISH, ST_RD_WORD and ST_RESP, then raises o_valid and returns
// to ST_IDLE with o_ready high. A miss scans all WAYS, then picks a free or
// random victim or runs a stamp scan, moves each block word by word over the
// memory port, checks a clean victim, and ends in the same closing states.
// After reset the backing memory is initialised one word a cycle, all
// MEM_WORDS words, with o_ready low. A result waits in o_rsp until taken.
// ----------------------------------------------------------------------------
module set_associative_cache_controller #(
    parameter int SETS      = sacc_pkg::SETS_DEF,
    parameter int WAYS      = sacc_pkg::WAYS_DEF,
    parameter int WPB       = sacc_pkg::WPB_DEF,
    parameter int MEM_WORDS = sacc_pkg::MEM_WORDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sacc_pkg::t_req   i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output sacc_pkg::t_rsp   o_rsp,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [1:0]       i_cfg_data
);
    import sacc_pkg::*;

    localparam int LINES = SETS * WAYS;
    localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int OW  = (WPB > 1) ? $clog2(WPB) : 1;
    localparam int LW  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int DW  = $clog2(LINES * WPB) > 0 ? $clog2(LINES * WPB) : 1;
    localparam int MW  = $clog2(MEM_WORDS);
    localparam int WIW = ADDR_W - 2;   // word index width
    localparam int TW  = ADDR_W;       // tag width, generous
    localparam int CW  = $clog2(WAYS + 1);

    // configuration
    logic       r_wt;
    logic [1:0] r_repl;

    // line state, flip-flops with reset
    logic              r_vld   [LINES];
    logic              r_dirty [LINES];
    logic [CW-1:0]     r_fill  [SETS];

    logic [DATA_W-1:0] r_clock, r_hits, r_misses;
    logic [15:0]       r_lfsr;

    t_state r_state, n_state;
    t_req   r_req;
    t_rsp   r_rsp;
    logic   r_ovalid;
    logic [WW-1:0] r_way;    // scan index
    logic [WW-1:0] r_sel;    // chosen way
    logic [DATA_W-1:0] r_best;   // best stamp seen in the victim scan
    logic          r_found;
    logic          r_wb;
    logic [OW:0]   r_cnt;
    logic [MW-1:0] r_init;
    logic [DATA_W-1:0] r_init_val;

    // address split
    logic [WIW-1:0] w_widx;
    logic [WIW-1:0] w_block;
    logic [SW-1:0]  w_set;
    logic [TW-1:0]  w_tag;
    logic [OW-1:0]  w_off;
    assign w_widx  = r_req.byte_address[ADDR_W-1:2];
    assign w_block = WIW'(w_widx / WIW'(WPB));
    assign w_set   = SW'(w_block % WIW'(SETS));
    assign w_tag   = TW'(w_block / WIW'(SETS));
    assign w_off   = OW'(w_widx % WIW'(WPB));

    // set of the request on the input, for the first tag read
    logic [WIW-1:0] w_in_block;
    logic [SW-1:0]  w_in_set;
    assign w_in_block = WIW'(i_req.byte_address[ADDR_W-1:2] / WIW'(WPB));
    assign w_in_set   = SW'(w_in_block % WIW'(SETS));

    logic [LW-1:0] w_line_scan, w_line_sel, w_line_next, w_line_base, w_line_in0;
    assign w_line_scan = LW'(int'(w_set) * WAYS + int'(r_way));
    assign w_line_sel  = LW'(int'(w_set) * WAYS + int'(r_sel));
    assign w_line_next = LW'(int'(w_set) * WAYS + int'(r_way) + 1);
    assign w_line_base = LW'(int'(w_set) * WAYS);
    assign w_line_in0  = LW'(int'(w_in_set) * WAYS);

    logic [OW-1:0] w_cnt_o;
    assign w_cnt_o = r_cnt[OW-1:0];

    // RAMs
    logic          dat_we;
    logic [DW-1:0] dat_wa, dat_ra;
    logic [DATA_W-1:0] dat_wd, dat_rd;
    logic          mem_we;
    logic [MW-1:0] mem_wa, mem_ra;
    logic [DATA_W-1:0] mem_wd, mem_rd;
    logic          tag_we;
    logic [LW-1:0] tag_ra;
    logic [TW-1:0] tag_rd;
    logic          ins_we, use_we;
    logic [LW-1:0] stamp_ra;
    logic [DATA_W-1:0] ins_rd, use_rd;

    sacc_ram #(.WIDTH(DATA_W), .DEPTH(LINES * WPB)) u_data (
        .i_clk(i_clk), .i_we(dat_we), .i_waddr(dat_wa), .i_wdata(dat_wd),
        .i_raddr(dat_ra), .o_rdata(dat_rd));
    sacc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_wa), .i_wdata(mem_wd),
        .i_raddr(mem_ra), .o_rdata(mem_rd));
    sacc_ram #(.WIDTH(TW), .DEPTH(LINES)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(w_line_sel), .i_wdata(w_tag),
        .i_raddr(tag_ra), .o_rdata(tag_rd));
    sacc_ram #(.WIDTH(DATA_W), .DEPTH(LINES)) u_ins (
        .i_clk(i_clk), .i_we(ins_we), .i_waddr(w_line_sel), .i_wdata(r_clock),
        .i_raddr(stamp_ra), .o_rdata(ins_rd));
    sacc_ram #(.WIDTH(DATA_W), .DEPTH(LINES)) u_use (
        .i_clk(i_clk), .i_we(use_we), .i_waddr(w_line_sel), .i_wdata(r_clock),
        .i_raddr(stamp_ra), .o_rdata(use_rd));

    logic [DW-1:0] w_dat_line;
    assign w_dat_line = DW'(int'(w_line_sel) * WPB + int'(w_cnt_o));
    logic [MW-1:0] w_vic_mem, w_new_mem;
    assign w_vic_mem = MW'((32'(tag_rd) * SETS + 32'(w_set)) * WPB
                           + 32'(w_cnt_o));
    assign w_new_mem = MW'(32'(w_block) * WPB + 32'(w_cnt_o));

    logic [15:0] w_lfsr_next;
    assign w_lfsr_next = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_MASK) : (r_lfsr >> 1);

    logic w_last;
    assign w_last = (int'(r_cnt) == WPB - 1);

    logic [DATA_W-1:0] w_stamp;
    logic              w_better;
    assign w_stamp  = (r_repl == REPL_LRU) ? use_rd : ins_rd;
    assign w_better = (r_repl == REPL_LRU) ? (w_stamp < r_best) : (w_stamp > r_best);

    logic w_rsp_load;
    assign w_rsp_load = (r_state == ST_RESP) && (!r_ovalid || i_ready);

    always_comb begin
        n_state = r_state;
        dat_we = 1'b0;
        dat_wa = w_dat_line;
        dat_wd = mem_rd;
        dat_ra = w_dat_line;
        mem_we = 1'b0;
        mem_wa = w_vic_mem;
        mem_wd = dat_rd;
        mem_ra = w_new_mem;
        tag_we = 1'b0;
        tag_ra = w_line_sel;
        ins_we = 1'b0;
        use_we = 1'b0;
        stamp_ra = w_line_base;
        unique case (r_state)
            ST_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_init;
                mem_wd = r_init_val;
                if (int'(r_init) == MEM_WORDS - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // fetch the tag of way 0 ahead of the scan
                tag_ra = w_line_in0;
                if (i_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                tag_ra = w_line_next;
                if (r_vld[w_line_scan] && tag_rd == w_tag) begin
                    n_state = ST_FINISH;
                end else if (int'(r_way) == WAYS - 1) begin
                    n_state = ST_VICTIM;
                end
            end
            ST_VICTIM: begin
                stamp_ra = w_line_next;
                if (int'(r_fill[w_set]) < WAYS || r_repl == REPL_RANDOM ||
                    int'(r_way) == WAYS - 1) begin
                    n_state = ST_WB_RD;
                end
            end
            ST_WB_RD: begin
                if (r_vld[w_line_sel] && r_dirty[w_line_sel]) begin
                    n_state = ST_WB_WR;
                end else begin
                    n_state = ST_FILL_RD;
                end
            end
            ST_WB_WR: begin
                mem_we = 1'b1;
                n_state = w_last ? ST_FILL_RD : ST_WB_RD;
            end
            ST_FILL_RD: begin
                n_state = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                dat_we = 1'b1;
                if (w_last) begin
                    tag_we = 1'b1;
                    ins_we = 1'b1;
                end
                n_state = w_last ? ST_FINISH : ST_FILL_RD;
            end
            ST_FINISH: begin
                dat_wa = DW'(int'(w_line_sel) * WPB + int'(w_off));
                dat_wd = r_req.write_data;
                mem_wa = MW'(w_widx);
                mem_wd = r_req.write_data;
                use_we = 1'b1;
                if (r_req.command == CMD_WRITE) begin
                    dat_we = 1'b1;
                    mem_we = r_wt;
                end
                n_state = ST_RD_WORD;
            end
            ST_RD_WORD: begin
                dat_ra = DW'(int'(w_line_sel) * WPB + int'(w_off));
                n_state = ST_RESP;
            end
            ST_RESP: begin
                // keep the word on the read port while the result stalls
                dat_ra = DW'(int'(w_line_sel) * WPB + int'(w_off));
                if (!r_ovalid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wt <= 1'b0;
            r_repl <= REPL_LRU;
            r_clock <= '0;
            r_hits <= '0;
            r_misses <= '0;
            r_lfsr <= LFSR_SEED;
            r_ovalid <= 1'b0;
            r_init <= '0;
            r_init_val <= '0;
            for (int i = 0; i < LINES; i++) begin
                r_vld[i] <= 1'b0;
                r_dirty[i] <= 1'b0;
            end
            for (int s = 0; s < SETS; s++) begin
                r_fill[s] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_WRITE_THROUGH) r_wt <= i_cfg_data[0];
                else                                  r_repl <= i_cfg_data;
            end
            if (w_rsp_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_INIT: begin
                    r_init <= r_init + 1'b1;
                    r_init_val <= r_init_val + DATA_W'(10);
                end
                ST_IDLE: begin
                    r_req <= i_req;
                    r_way <= '0;
                    r_wb <= 1'b0;
                    r_cnt <= '0;
                    if (i_valid) begin
                        r_clock <= sat_inc(r_clock);
                    end
                end
                ST_LOOKUP: begin
                    if (r_vld[w_line_scan] && tag_rd == w_tag) begin
                        r_sel <= r_way;
                        r_found <= 1'b1;
                        r_hits <= sat_inc(r_hits);
                    end else if (int'(r_way) == WAYS - 1) begin
                        r_found <= 1'b0;
                        r_misses <= sat_inc(r_misses);
                        r_sel <= '0;
                        r_way <= '0;
                    end else begin
                        r_way <= r_way + 1'b1;
                    end
                end
                ST_VICTIM: begin
                    // pick: free way, random, or scan with one compare a cycle
                    priority if (int'(r_fill[w_set]) < WAYS) begin
                        r_sel <= WW'(r_fill[w_set]);
                        r_fill[w_set] <= r_fill[w_set] + 1'b1;
                    end else if (r_repl == REPL_RANDOM) begin
                        r_lfsr <= w_lfsr_next;
                        r_sel <= WW'(int'(w_lfsr_next) % WAYS);
                    end else begin
                        if (r_way == '0 || w_better) begin
                            r_best <= w_stamp;
                            r_sel <= r_way;
                        end
                        if (int'(r_way) != WAYS - 1) r_way <= r_way + 1'b1;
                    end
                end
                ST_WB_RD: begin
                    if (r_vld[w_line_sel] && r_dirty[w_line_sel]) r_wb <= 1'b1;
                end
                ST_WB_WR: begin
                    r_cnt <= w_last ? '0 : r_cnt + 1'b1;
                end
                ST_FILL_WR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_vld[w_line_sel] <= 1'b1;
                        r_dirty[w_line_sel] <= 1'b0;
                    end
                end
                ST_FINISH: begin
                    if (r_req.command == CMD_WRITE && !r_wt) begin
                        r_dirty[w_line_sel] <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // hold result fields; word arrives from RAM in the response state
    always_ff @(posedge i_clk) begin
        if (w_rsp_load) begin
            r_rsp.was_hit    <= r_found;
            r_rsp.word_value <= dat_rd;
            r_rsp.wrote_back <= r_wb;
            r_rsp.hit_total  <= r_hits;
            r_rsp.miss_total <= r_misses;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;
endmodule
